// File: hdl/mcfb_pkg.sv
// Shared types and constants for the motor command frame builder.
// No dependencies.
package mcfb_pkg;

	localparam int POSITION_BITS = 16;
	localparam int CHANNEL_BITS  = 12;
	// One quotient bit per stage, sized for the widest code.
	localparam int DIV_STEPS = (POSITION_BITS > CHANNEL_BITS) ? POSITION_BITS : CHANNEL_BITS;
	// Clamp stage, dividend stage, then the division stages.
	localparam int NSTG   = DIV_STEPS + 2;
	localparam int QW     = DIV_STEPS;
	localparam int LIM_W  = 31;
	localparam int SPAN_W = LIM_W + 1;
	localparam int DVS_W  = SPAN_W + 1;
	localparam int DW     = SPAN_W + DIV_STEPS + 2;
	localparam int SHW    = $clog2(DIV_STEPS + 2);

	localparam logic [7:0] EN_LAST  = 8'hFC;
	localparam logic [7:0] DIS_LAST = 8'hFD;

	typedef enum logic [1:0] {
		REQ_SETPOINT = 2'd0,
		REQ_ENABLE   = 2'd1,
		REQ_DISABLE  = 2'd2,
		REQ_INVALID  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		CM_MIT       = 2'd0,
		CM_POS_SPEED = 2'd1,
		CM_SPEED     = 2'd2,
		CM_FORCE_POS = 2'd3
	} ctrl_mode_t;

	typedef enum logic [2:0] {
		REG_CONTROL_MODE = 3'd0,
		REG_MOTOR_ID     = 3'd1,
		REG_POS_LIMIT    = 3'd2,
		REG_VEL_LIMIT    = 3'd3,
		REG_KP_LIMIT     = 3'd4,
		REG_KD_LIMIT     = 3'd5,
		REG_TRQ_LIMIT    = 3'd6,
		REG_SPARE        = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] frame_id;
		logic [63:0] payload;
		logic        status;
		logic        mit;
	} ctl_t;

	function automatic logic [31:0] byte_swap32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [15:0] byte_swap16(input logic [15:0] w);
		return {w[7:0], w[15:8]};
	endfunction

endpackage

// File: hdl/mcfb_chan.sv
// One MIT channel: clamp, scaled dividend, then a restoring divider one
// quotient bit per stage. Depends on mcfb_pkg.
module mcfb_chan (
	input  logic                        clk,
	input  logic [mcfb_pkg::NSTG-1:0]   en,
	input  logic signed [31:0]          x,
	input  logic [mcfb_pkg::LIM_W-1:0]  limit,
	input  logic                        sym,
	input  logic [mcfb_pkg::SHW-1:0]    qbits,
	output logic [mcfb_pkg::QW-1:0]     code
);
	import mcfb_pkg::*;

	logic signed [LIM_W+2:0] lo, hi, xs, xc;
	logic [SPAN_W-1:0]       num_s1, span_s1;
	logic                    zero_s1;

	always_comb begin
		hi = $signed({3'b000, limit});
		lo = sym ? -hi : '0;
		xs = (LIM_W+3)'(x);
		if (xs < lo)
			xc = lo;
		else if (xs > hi)
			xc = hi;
		else
			xc = xs;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_s1  <= SPAN_W'(xc - lo);
			span_s1 <= sym ? {limit, 1'b0} : {1'b0, limit};
			zero_s1 <= (limit == '0);
		end
	end

	// 2*num*(2^bits-1) + span, with the multiply done as shift minus value
	logic [DW-1:0]    rem_s [0:DIV_STEPS];
	logic [DVS_W-1:0] dvs_s [0:DIV_STEPS];
	logic [QW-1:0]    q_s   [0:DIV_STEPS];
	logic             zero_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rem_s[0]  <= (DW'(num_s1) << (qbits + SHW'(1))) - (DW'(num_s1) << 1)
				+ DW'(span_s1);
			dvs_s[0]  <= {span_s1, 1'b0};
			q_s[0]    <= '0;
			zero_s[0] <= zero_s1;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int B = DIV_STEPS - 1 - j;
		logic [DW:0] trial;
		assign trial = {1'b0, rem_s[j]} - ((DW+1)'(dvs_s[j]) << B);
		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				rem_s[j+1]  <= trial[DW] ? rem_s[j] : trial[DW-1:0];
				q_s[j+1]    <= q_s[j] | (trial[DW] ? QW'(0) : (QW'(1) << B));
				dvs_s[j+1]  <= dvs_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
	end

	assign code = zero_s[DIV_STEPS] ? '0 : q_s[DIV_STEPS];

endmodule

// File: hdl/motor_command_frame_builder_core.sv
// Top level of the motor command frame builder: registers, control pipeline
// and five mcfb_chan dividers. Depends on mcfb_pkg and mcfb_chan.
//
// channel  signals                      transfer when
// in       in_valid/in_stall + fields   in_valid && !in_stall
// out      out_valid/out_stall + fields out_valid && !out_stall
// cfg      cfg_we/cfg_index/cfg_data    cfg_we
//
// Stages: clamp, dividend, 16 divider stages; one item per cycle while the output is not stalled.
// The divider depth is set by the 16-bit position code.
// Reset clears valid bits and loads register defaults.
// A stall at the output fills empty stages first, then holds the input.
module motor_command_frame_builder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      mode,
	input  logic signed [31:0]              position,
	input  logic signed [31:0]              velocity,
	input  logic signed [31:0]              stiffness,
	input  logic signed [31:0]              damping,
	input  logic signed [31:0]              torque,
	input  logic [31:0]                     position_word,
	input  logic [31:0]                     velocity_word,
	input  logic [15:0]                     pvt_velocity,
	input  logic [15:0]                     current_target,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [10:0]                     frame_id,
	output logic [63:0]                     payload,
	output logic                            status,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [mcfb_pkg::LIM_W-1:0]      cfg_data
);
	import mcfb_pkg::*;

	ctrl_mode_t       control_mode_q;
	logic [7:0]       motor_id_q;
	logic [LIM_W-1:0] pos_lim_q, vel_lim_q, kp_lim_q, kd_lim_q, trq_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_mode_q <= CM_MIT;
			motor_id_q     <= 8'd1;
			pos_lim_q      <= LIM_W'(819200);
			vel_lim_q      <= LIM_W'(2949120);
			kp_lim_q       <= LIM_W'(32768000);
			kd_lim_q       <= LIM_W'(327680);
			trq_lim_q      <= LIM_W'(3276800);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CONTROL_MODE: control_mode_q <= ctrl_mode_t'(cfg_data[1:0]);
				REG_MOTOR_ID:     motor_id_q     <= cfg_data[7:0];
				REG_POS_LIMIT:    pos_lim_q      <= cfg_data;
				REG_VEL_LIMIT:    vel_lim_q      <= cfg_data;
				REG_KP_LIMIT:     kp_lim_q       <= cfg_data;
				REG_KD_LIMIT:     kd_lim_q       <= cfg_data;
				REG_TRQ_LIMIT:    trq_lim_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one moves
	logic [NSTG-1:0] v_q, en;
	always_comb begin
		en[NSTG-1] = !v_q[NSTG-1] || !out_stall;
		for (int k = NSTG-2; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end
	assign in_stall  = !en[0];
	assign out_valid = v_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	ctl_t ctl_in;
	always_comb begin
		ctl_in.frame_id = 11'({control_mode_q, 8'h00}) + 11'(motor_id_q);
		ctl_in.status   = 1'b0;
		ctl_in.mit      = 1'b0;
		ctl_in.payload  = '0;
		case (req_e_t'(mode))
			REQ_INVALID: begin
				ctl_in.frame_id = '0;
				ctl_in.status   = 1'b1;
			end
			REQ_ENABLE:  ctl_in.payload = {56'hFF_FFFF_FFFF_FFFF, EN_LAST};
			REQ_DISABLE: ctl_in.payload = {56'hFF_FFFF_FFFF_FFFF, DIS_LAST};
			default: begin
				case (control_mode_q)
					CM_MIT:       ctl_in.mit = 1'b1;
					CM_POS_SPEED: ctl_in.payload = {byte_swap32(position_word),
						byte_swap32(velocity_word)};
					CM_SPEED:     ctl_in.payload = {byte_swap32(velocity_word), 32'h0};
					default:      ctl_in.payload = {byte_swap32(position_word),
						byte_swap16(pvt_velocity), byte_swap16(current_target)};
				endcase
			end
		endcase
	end

	ctl_t ctl_s [0:NSTG-1];
	always_ff @(posedge clk) begin
		if (en[0])
			ctl_s[0] <= ctl_in;
		for (int k = 1; k < NSTG; k++)
			if (en[k])
				ctl_s[k] <= ctl_s[k-1];
	end

	logic [QW-1:0] p_code, v_code, kp_code, kd_code, t_code;

	mcfb_chan u_pos (.clk, .en, .x(position), .limit(pos_lim_q), .sym(1'b1),
		.qbits(SHW'(POSITION_BITS)), .code(p_code));
	mcfb_chan u_vel (.clk, .en, .x(velocity), .limit(vel_lim_q), .sym(1'b1),
		.qbits(SHW'(CHANNEL_BITS)), .code(v_code));
	mcfb_chan u_kp (.clk, .en, .x(stiffness), .limit(kp_lim_q), .sym(1'b0),
		.qbits(SHW'(CHANNEL_BITS)), .code(kp_code));
	mcfb_chan u_kd (.clk, .en, .x(damping), .limit(kd_lim_q), .sym(1'b0),
		.qbits(SHW'(CHANNEL_BITS)), .code(kd_code));
	mcfb_chan u_trq (.clk, .en, .x(torque), .limit(trq_lim_q), .sym(1'b1),
		.qbits(SHW'(CHANNEL_BITS)), .code(t_code));

	logic [63:0] mit_payload;
	assign mit_payload = {16'(p_code), 12'(v_code), 12'(kp_code), 12'(kd_code),
		12'(t_code)};

	assign frame_id = ctl_s[NSTG-1].frame_id;
	assign status   = ctl_s[NSTG-1].status;
	assign payload  = ctl_s[NSTG-1].mit ? mit_payload : ctl_s[NSTG-1].payload;

`ifndef SYNTHESIS
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input held back with room in the pipeline");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
	a_invalid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (frame_id == '0 && payload == '0))
		else $error("invalid request carries a frame");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking regression for motor_command_frame_builder_core.
// Predicts each frame in a small scoreboard class; depends on mcfb_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mcfb_pkg::*;

	class frame_scoreboard;
		logic [1:0]  cm;
		logic [7:0]  mid;
		logic [30:0] lim_pos, lim_vel, lim_kp, lim_kd, lim_trq;
		logic [10:0] q_id[$];
		logic [63:0] q_pl[$];
		logic        q_st[$];
		int mismatches;
		int checked;

		function void reset_regs();
			cm = CM_MIT; mid = 8'd1;
			lim_pos = 31'd819200; lim_vel = 31'd2949120; lim_kp = 31'd32768000;
			lim_kd = 31'd327680; lim_trq = 31'd3276800;
		endfunction

		function void write_reg(reg_idx_t idx, logic [30:0] v);
			case (idx)
				REG_CONTROL_MODE: cm = v[1:0];
				REG_MOTOR_ID:     mid = v[7:0];
				REG_POS_LIMIT:    lim_pos = v;
				REG_VEL_LIMIT:    lim_vel = v;
				REG_KP_LIMIT:     lim_kp = v;
				REG_KD_LIMIT:     lim_kd = v;
				REG_TRQ_LIMIT:    lim_trq = v;
				default: ;
			endcase
		endfunction

		function logic [63:0] code_of(longint x, longint lo, longint hi, int bits);
			longint unsigned num, span, top;
			if (hi <= lo) return 0;
			if (x < lo) x = lo;
			if (x > hi) x = hi;
			num = x - lo;
			span = hi - lo;
			top = (64'd1 << bits) - 1;
			return (2 * num * top + span) / (2 * span);
		endfunction

		function logic [31:0] le32(logic [31:0] w);
			return {w[7:0], w[15:8], w[23:16], w[31:24]};
		endfunction

		function void note_request(logic [1:0] req, logic signed [31:0] p, v, kp, kd, t,
				logic [31:0] pw, vw, logic [15:0] pv, ct);
			logic [63:0] pl;
			logic [63:0] cp, cv, ck, cd, ctq;
			if (req == REQ_INVALID) begin
				q_id.push_back(0); q_pl.push_back(0); q_st.push_back(1);
				return;
			end
			if (req == REQ_ENABLE) pl = {56'hFFFFFFFFFFFFFF, EN_LAST};
			else if (req == REQ_DISABLE) pl = {56'hFFFFFFFFFFFFFF, DIS_LAST};
			else if (cm == CM_MIT) begin
				cp = code_of(p, -longint'(lim_pos), longint'(lim_pos), POSITION_BITS);
				cv = code_of(v, -longint'(lim_vel), longint'(lim_vel), CHANNEL_BITS);
				ck = code_of(kp, 0, longint'(lim_kp), CHANNEL_BITS);
				cd = code_of(kd, 0, longint'(lim_kd), CHANNEL_BITS);
				ctq = code_of(t, -longint'(lim_trq), longint'(lim_trq), CHANNEL_BITS);
				pl = {cp[15:0], cv[11:0], ck[11:0], cd[11:0], ctq[11:0]};
			end else if (cm == CM_POS_SPEED) pl = {le32(pw), le32(vw)};
			else if (cm == CM_SPEED) pl = {le32(vw), 32'd0};
			else pl = {le32(pw), pv[7:0], pv[15:8], ct[7:0], ct[15:8]};
			q_id.push_back(11'({3'd0, cm, 8'd0} + {3'd0, mid}));
			q_pl.push_back(pl);
			q_st.push_back(0);
		endfunction

		function void check_frame(logic [10:0] id, logic [63:0] pl, logic st);
			logic [10:0] eid;
			logic [63:0] epl;
			logic est;
			if (q_id.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected frame id=%h payload=%h", id, pl);
				return;
			end
			eid = q_id.pop_front(); epl = q_pl.pop_front(); est = q_st.pop_front();
			checked++;
			if (id !== eid || pl !== epl || st !== est) begin
				mismatches++;
				if (mismatches <= 10)
					$display("frame mismatch: exp id=%h pl=%h st=%b got id=%h pl=%h st=%b",
						eid, epl, est, id, pl, st);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_we = 0;
	logic in_stall, out_valid, status;
	logic [1:0] mode = 0;
	logic signed [31:0] position = 0, velocity = 0, stiffness = 0, damping = 0, torque = 0;
	logic [31:0] position_word = 0, velocity_word = 0;
	logic [15:0] pvt_velocity = 0, current_target = 0;
	logic [10:0] frame_id;
	logic [63:0] payload;
	logic [2:0] cfg_index = 0;
	logic [30:0] cfg_data = 0;

	frame_scoreboard sb = new();
	bit quiet = 0;       // no idling in the final stretch
	bit hold_long = 0;   // receiver hold-off request

	always #10 clk = ~clk;

	motor_command_frame_builder_core dut (.*);

	// output sampling at the rising edge
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) sb.check_frame(frame_id, payload, status);

	// receiver stall process
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1;
				repeat (60) @(negedge clk);
				out_stall <= 0;
				hold_long = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 9);
				out_stall <= 1;
				repeat (n) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	function logic [31:0] edge_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// one input transfer; called at a falling edge, returns at a falling edge
	// with valid still high, so the next call can follow without a gap
	task automatic send_request(logic [1:0] m, logic [31:0] p, v, kp, kd, t, pw, vw,
			logic [15:0] pv, ct);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		mode <= m; position <= p; velocity <= v; stiffness <= kp; damping <= kd;
		torque <= t; position_word <= pw; velocity_word <= vw;
		pvt_velocity <= pv; current_target <= ct;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(m, p, v, kp, kd, t, pw, vw, pv, ct);
		@(negedge clk);
	endtask

	task automatic send_random(bit mostly_setpoint);
		logic [1:0] m;
		m = mostly_setpoint && $urandom_range(0, 3) != 0 ? REQ_SETPOINT : 2'($urandom);
		send_request(m, edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
			$urandom, $urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.q_id.size() != 0) @(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [30:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic random_limits();
		for (int r = REG_POS_LIMIT; r <= REG_TRQ_LIMIT; r++)
			case ($urandom_range(0, 3))
				0: write_reg(reg_idx_t'(r), 31'd1);
				1: write_reg(reg_idx_t'(r), 31'h7FFF_FFFF);
				2: write_reg(reg_idx_t'(r), 31'($urandom_range(1, 32'h0100_0000)));
				default: write_reg(reg_idx_t'(r), 31'($urandom) | 31'd1);
			endcase
	endtask

	initial begin
		sb.reset_regs();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: defaults, every request, channel extremes
		for (int m = 0; m < 4; m++)
			send_request(m[1:0], 0, 0, 0, 0, 0, 32'h1234_5678, 32'h9ABC_DEF0, 16'hA55A, 16'h0FF0);
		send_request(REQ_SETPOINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
		send_request(REQ_SETPOINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_request(REQ_SETPOINT, 32'd409600, -32'sd1474560, 32'd16384000,
			32'd163840, 32'd1, 0, 0, 0, 0);
		drain();
		write_reg(REG_SPARE, 31'h7FFF_FFFF);   // ignored index
		for (int r = REG_POS_LIMIT; r <= REG_TRQ_LIMIT; r++) write_reg(reg_idx_t'(r), 31'd0);
		send_request(REQ_SETPOINT, 32'd5, -32'sd5, 32'd5, 32'd5, 32'd5, 0, 0, 0, 0);
		drain();
		for (int r = REG_POS_LIMIT; r <= REG_TRQ_LIMIT; r++) write_reg(reg_idx_t'(r), 31'd1);
		send_request(REQ_SETPOINT, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1, -32'sd1, 0, 0, 0, 0);
		drain();
		for (int c = 0; c < 4; c++) begin
			write_reg(REG_CONTROL_MODE, 31'(c));
			write_reg(REG_MOTOR_ID, c[0] ? 31'd255 : 31'd0);
			for (int k = 0; k < 3; k++) send_random(1);
			drain();
		end
		// random phases across configurations
		for (int ph = 0; ph < 16; ph++) begin
			write_reg(REG_CONTROL_MODE, 31'(ph % 4 == 3 ? $urandom_range(1, 3) : 0));
			write_reg(REG_MOTOR_ID, 31'($urandom_range(0, 255)));
			random_limits();
			if (ph == 14) quiet = 1;
			if (ph == 3) hold_long = 1;
			for (int i = 0; i < 125; i++) send_random(1);
			drain();
		end
		$display("covered all request kinds in every control mode, zero/unit/max limits,");
		$display("%0d frames checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.q_id.size() == 0)
			$display("motor_command_frame_builder_core regression: pass");
		else
			$display("motor_command_frame_builder_core regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("motor_command_frame_builder_core regression: fail");
		$finish;
	end
endmodule

// File: filelist.f
hdl/mcfb_pkg.sv
hdl/mcfb_chan.sv
hdl/motor_command_frame_builder_core.sv
verif/tb_top.sv
